### design/rotation_matrix_to_quaternion_macros.svh
// Assertion macros shared by the rotation matrix to quaternion design.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rmq_pkg.sv
// Shared types, constants and width functions for the quaternion converter.
`default_nettype none
package rmq_pkg;

    localparam int NUM_COMP = 4;

    typedef enum logic [1:0] {
        SLOT_X = 2'd0,
        SLOT_Y = 2'd1,
        SLOT_Z = 2'd2,
        SLOT_W = 2'd3
    } comp_slot_t;

    typedef struct packed {
        comp_slot_t slot;
        logic       degen;
    } front_tag_t;

    // Width of the signed square root argument.
    function automatic int arg_width(input int dw, input int fb);
        arg_width = ((dw > fb + 1) ? dw : fb + 1) + 3;
    endfunction

    // Width of the unsigned square root input, argument scaled by 2^(fb-2).
    function automatic int root_in_width(input int dw, input int fb);
        root_in_width = arg_width(dw, fb) - 1 + fb - 2;
    endfunction

endpackage
`default_nettype wire

### design/rotation_matrix_to_quaternion.sv
// Pipeline: front stage, square root pipeline, operand prep register, divider pipeline, output register.
// Throughput: one matrix per cycle unless a result waits at the output; the square root
// pipeline and the divider pipeline each resolve one result bit per stage.
// Reset clears all valid bits asynchronously; no item is held after reset.
`default_nettype none
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill to whole bytes
    input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // quat_x, quat_y, quat_z, quat_w, zero fill to whole bytes
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // degenerate
    output logic      m_tuser
);
    `include "rotation_matrix_to_quaternion_macros.svh"

    localparam int W      = DATA_WIDTH;
    localparam int DW     = W + 1;
    localparam int L      = rmq_pkg::NUM_COMP;
    localparam int XW     = rmq_pkg::root_in_width(W, FRAC_BITS);
    localparam int LW     = (XW + 1) / 2 + 1;
    localparam int CW     = (LW > W) ? LW : W;
    localparam int NW     = ((DW + FRAC_BITS > LW + 1) ? DW + FRAC_BITS : LW + 1) + 1;
    localparam int DENW   = LW + 2;
    localparam int OUT_TW = ((4 * W + 7) / 8) * 8;
    localparam int FT_W   = $bits(rmq_pkg::front_tag_t);
    localparam int ST_W   = FT_W + L * DW;
    localparam int VT_W   = FT_W + L + W;
    localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

    logic en;

    logic                 f_valid;
    logic [XW-1:0]        f_x;
    logic signed [DW-1:0] f_d [L];
    rmq_pkg::front_tag_t  f_tag;
    logic [ST_W-1:0]      f_stag;

    logic                 s_valid;
    logic [LW-1:0]        s_root;
    logic [ST_W-1:0]      s_stag;
    rmq_pkg::front_tag_t  s_ftag;
    logic signed [DW-1:0] s_d [L];

    logic                 prep_valid_reg;
    logic [NW-1:0]        num_reg [L];
    logic [DENW-1:0]      den_reg;
    rmq_pkg::front_tag_t  prep_ftag_reg;
    logic [L-1:0]         neg_reg;
    logic [W-1:0]         lead_sat_reg;
    logic [DW-1:0]        mag [L];
    logic [W-1:0]         lead_sat_next;

    logic                 v_valid;
    logic [W-1:0]         v_quo [L];
    logic                 v_ovf [L];
    logic [VT_W-1:0]      v_tag;
    rmq_pkg::front_tag_t  v_ftag;
    logic [L-1:0]         v_neg;
    logic [W-1:0]         v_lead;
    logic [W-1:0]         comp_next [L];

    logic                 m_tvalid_reg;
    logic [OUT_TW-1:0]    m_tdata_reg;
    logic                 m_tuser_reg;

    // The whole pipeline advances together; it holds only while a result
    // waits at the output for its transfer.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    rmq_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .m00       (s_tdata[0*W +: W]),
        .m01       (s_tdata[1*W +: W]),
        .m02       (s_tdata[2*W +: W]),
        .m10       (s_tdata[3*W +: W]),
        .m11       (s_tdata[4*W +: W]),
        .m12       (s_tdata[5*W +: W]),
        .m20       (s_tdata[6*W +: W]),
        .m21       (s_tdata[7*W +: W]),
        .m22       (s_tdata[8*W +: W]),
        .out_valid (f_valid),
        .out_x     (f_x),
        .out_d     (f_d),
        .out_tag   (f_tag)
    );

    assign f_stag = {f_tag, f_d[3], f_d[2], f_d[1], f_d[0]};

    rmq_sqrt #(
        .IN_W  (XW),
        .TAG_W (ST_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_x      (f_x),
        .in_tag    (f_stag),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_tag   (s_stag)
    );

    assign s_ftag = s_stag[ST_W-1 -: FT_W];
    for (genvar n = 0; n < L; n++)
    begin : g_unpack
        assign s_d[n] = s_stag[n*DW +: DW];
        assign mag[n] = s_d[n][DW-1] ? DW'(-s_d[n]) : DW'(s_d[n]);
    end

    assign lead_sat_next = (CW'(s_root) > CW'(QMAX)) ? QMAX : W'(s_root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int n = 0; n < L; n++)
            begin
                num_reg[n] <= (NW'(mag[n]) << FRAC_BITS) + NW'({s_root, 1'b0});
                neg_reg[n] <= s_d[n][DW-1];
            end
            den_reg       <= {s_root, 2'b00};
            prep_ftag_reg <= s_ftag;
            lead_sat_reg  <= lead_sat_next;
        end
    end

    rmq_div #(
        .NUM_W (NW),
        .DEN_W (DENW),
        .QUO_W (W),
        .TAG_W (VT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .in_tag    ({prep_ftag_reg, neg_reg, lead_sat_reg}),
        .out_valid (v_valid),
        .out_quo   (v_quo),
        .out_ovf   (v_ovf),
        .out_tag   (v_tag)
    );

    assign v_ftag = v_tag[VT_W-1 -: FT_W];
    assign v_neg  = v_tag[W +: L];
    assign v_lead = v_tag[W-1:0];

    always_comb
    begin
        for (int c = 0; c < L; c++)
        begin
            logic big;
            big = v_ovf[c] || v_quo[c][W-1];
            priority if (v_ftag.degen)
            begin
                comp_next[c] = '0;
            end
            else if (v_ftag.slot == rmq_pkg::comp_slot_t'(c))
            begin
                comp_next[c] = v_lead;
            end
            else if (v_neg[c])
            begin
                comp_next[c] = big ? QMIN : W'(-v_quo[c]);
            end
            else
            begin
                comp_next[c] = big ? QMAX : v_quo[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= v_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= OUT_TW'({comp_next[3], comp_next[2], comp_next[1], comp_next[0]});
            m_tuser_reg <= v_ftag.degen;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `RMQ_ASSERT_IMPL(a_degen_zero, m_tvalid && m_tuser, m_tdata == '0, "degenerate result not zero")
    `RMQ_ASSERT_IMPL(a_stall_only_full, !s_tready, m_tvalid, "input stalled with empty output")
    `RMQ_ASSERT_IMPL(a_degen_root_zero, s_valid && s_ftag.degen, s_root == '0, "degenerate root nonzero")
    `RMQ_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result lost")
endmodule
`default_nettype wire

### design/rmq_front.sv
// Front stage: trace, leading component choice, root argument and pair terms.
`default_nettype none
module rmq_front #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic signed [DATA_WIDTH-1:0] m00,
    input  wire logic signed [DATA_WIDTH-1:0] m01,
    input  wire logic signed [DATA_WIDTH-1:0] m02,
    input  wire logic signed [DATA_WIDTH-1:0] m10,
    input  wire logic signed [DATA_WIDTH-1:0] m11,
    input  wire logic signed [DATA_WIDTH-1:0] m12,
    input  wire logic signed [DATA_WIDTH-1:0] m20,
    input  wire logic signed [DATA_WIDTH-1:0] m21,
    input  wire logic signed [DATA_WIDTH-1:0] m22,
    output logic                              out_valid,
    output logic [rmq_pkg::root_in_width(DATA_WIDTH, FRAC_BITS)-1:0] out_x,
    output logic signed [DATA_WIDTH:0]        out_d [rmq_pkg::NUM_COMP],
    output rmq_pkg::front_tag_t               out_tag
);
    localparam int AW = rmq_pkg::arg_width(DATA_WIDTH, FRAC_BITS);
    localparam int XW = rmq_pkg::root_in_width(DATA_WIDTH, FRAC_BITS);
    localparam int DW = DATA_WIDTH + 1;
    localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

    logic signed [AW-1:0] a00, a11, a22, trace, arg;
    logic signed [DW-1:0] d_next [rmq_pkg::NUM_COMP];
    logic [XW-1:0]        x_next;
    rmq_pkg::front_tag_t  tag_next;

    logic                 valid_reg;
    logic [XW-1:0]        x_reg;
    logic signed [DW-1:0] d_reg [rmq_pkg::NUM_COMP];
    rmq_pkg::front_tag_t  tag_reg;

    assign a00   = AW'(m00);
    assign a11   = AW'(m11);
    assign a22   = AW'(m22);
    assign trace = a00 + a11 + a22;

    always_comb
    begin
        for (int c = 0; c < rmq_pkg::NUM_COMP; c++)
        begin
            d_next[c] = '0;
        end
        priority if (trace > 0)
        begin
            tag_next.slot = rmq_pkg::SLOT_W;
        end
        else if (m00 < m11)
        begin
            tag_next.slot = (m11 < m22) ? rmq_pkg::SLOT_Z : rmq_pkg::SLOT_Y;
        end
        else
        begin
            tag_next.slot = (m00 < m22) ? rmq_pkg::SLOT_Z : rmq_pkg::SLOT_X;
        end
        unique case (tag_next.slot)
            rmq_pkg::SLOT_W:
            begin
                arg       = trace + ONE;
                d_next[0] = DW'(m21) - DW'(m12);
                d_next[1] = DW'(m02) - DW'(m20);
                d_next[2] = DW'(m10) - DW'(m01);
            end
            rmq_pkg::SLOT_X:
            begin
                arg       = a00 - a11 - a22 + ONE;
                d_next[1] = DW'(m10) + DW'(m01);
                d_next[2] = DW'(m20) + DW'(m02);
                d_next[3] = DW'(m21) - DW'(m12);
            end
            rmq_pkg::SLOT_Y:
            begin
                arg       = a11 - a22 - a00 + ONE;
                d_next[0] = DW'(m01) + DW'(m10);
                d_next[2] = DW'(m21) + DW'(m12);
                d_next[3] = DW'(m02) - DW'(m20);
            end
            default:
            begin
                arg       = a22 - a00 - a11 + ONE;
                d_next[0] = DW'(m02) + DW'(m20);
                d_next[1] = DW'(m12) + DW'(m21);
                d_next[3] = DW'(m10) - DW'(m01);
            end
        endcase
        tag_next.degen = (arg <= 0);
        x_next = tag_next.degen ? '0 : (XW'(arg[AW-2:0]) << (FRAC_BITS - 2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            d_reg   <= d_next;
            tag_reg <= tag_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_d     = d_reg;
    assign out_tag   = tag_reg;
endmodule
`default_nettype wire

### design/rmq_sqrt.sv
// Pipelined square root, two radicand bits per stage, rounded to nearest.
`default_nettype none
module rmq_sqrt #(
    parameter int IN_W  = 30,
    parameter int TAG_W = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [IN_W-1:0]       in_x,
    input  wire logic [TAG_W-1:0]      in_tag,
    output logic                       out_valid,
    output logic [(IN_W+1)/2:0]        out_root,
    output logic [TAG_W-1:0]           out_tag
);
    localparam int N   = (IN_W + 1) / 2;
    localparam int XP  = 2 * N;
    localparam int RMW = N + 1;

    logic             cur_valid [N+1];
    logic [XP-1:0]    cur_x     [N+1];
    logic [RMW-1:0]   cur_rem   [N+1];
    logic [N-1:0]     cur_root  [N+1];
    logic [TAG_W-1:0] cur_tag   [N+1];

    logic             valid_reg [N];
    logic [XP-1:0]    x_reg     [N];
    logic [RMW-1:0]   rem_reg   [N];
    logic [N-1:0]     root_reg  [N];
    logic [TAG_W-1:0] tag_reg   [N];

    logic             out_valid_reg;
    logic [RMW-1:0]   out_root_reg;
    logic [TAG_W-1:0] out_tag_reg;
    logic [RMW-1:0]   root_ext;

    assign cur_valid[0] = in_valid;
    assign cur_x[0]     = XP'(in_x);
    assign cur_rem[0]   = '0;
    assign cur_root[0]  = '0;
    assign cur_tag[0]   = in_tag;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [RMW+1:0] rem2, trial, diff;
        logic           take;

        assign rem2  = {cur_rem[k], cur_x[k][XP-1-2*k -: 2]};
        assign trial = (RMW+2)'({cur_root[k], 2'b01});
        assign take  = (rem2 >= trial);
        assign diff  = rem2 - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= cur_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k]    <= cur_x[k];
                rem_reg[k]  <= take ? diff[RMW-1:0] : rem2[RMW-1:0];
                root_reg[k] <= {cur_root[k][N-2:0], take};
                tag_reg[k]  <= cur_tag[k];
            end
        end

        assign cur_valid[k+1] = valid_reg[k];
        assign cur_x[k+1]     = x_reg[k];
        assign cur_rem[k+1]   = rem_reg[k];
        assign cur_root[k+1]  = root_reg[k];
        assign cur_tag[k+1]   = tag_reg[k];
    end

    // Round up when the remainder exceeds the root, i.e. the radicand lies
    // at or above the midpoint to the next square.
    assign root_ext = {1'b0, cur_root[N]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= cur_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_root_reg <= root_ext + RMW'(cur_rem[N] > root_ext);
            out_tag_reg  <= cur_tag[N];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_root  = out_root_reg;
    assign out_tag   = out_tag_reg;
endmodule
`default_nettype wire

### design/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage, four lanes with a shared divisor.
`default_nettype none
module rmq_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 12,
    parameter int QUO_W = 16,
    parameter int TAG_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] in_num [rmq_pkg::NUM_COMP],
    input  wire logic [DEN_W-1:0] in_den,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_valid,
    output logic [QUO_W-1:0]      out_quo [rmq_pkg::NUM_COMP],
    output logic                  out_ovf [rmq_pkg::NUM_COMP],
    output logic [TAG_W-1:0]      out_tag
);
    localparam int HI_W = NUM_W - QUO_W;
    localparam int RW   = ((HI_W > DEN_W) ? HI_W : DEN_W) + 1;
    localparam int L    = rmq_pkg::NUM_COMP;

    // Stage 0 loads the high numerator bits and flags quotients that do not
    // fit in QUO_W bits; those lanes saturate later.
    logic             valid_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg   [QUO_W+1];
    logic [TAG_W-1:0] tag_reg   [QUO_W+1];
    logic [RW-1:0]    rem_reg   [QUO_W+1][L];
    logic [QUO_W-1:0] lo_reg    [QUO_W+1][L];
    logic [QUO_W-1:0] quo_reg   [QUO_W+1][L];
    logic             ovf_reg   [QUO_W+1][L];
    logic [RW-1:0]    hi_in     [L];

    for (genvar n = 0; n < L; n++)
    begin : g_load
        assign hi_in[n] = RW'(in_num[n][NUM_W-1:QUO_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= in_den;
            tag_reg[0] <= in_tag;
            for (int n = 0; n < L; n++)
            begin
                rem_reg[0][n] <= hi_in[n];
                lo_reg[0][n]  <= in_num[n][QUO_W-1:0];
                quo_reg[0][n] <= '0;
                ovf_reg[0][n] <= (hi_in[n] >= RW'(in_den));
            end
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [RW:0] rem2 [L];
        logic [RW:0] diff [L];
        logic        take [L];

        for (genvar n = 0; n < L; n++)
        begin : g_lane
            assign rem2[n] = {rem_reg[k][n], lo_reg[k][n][QUO_W-1-k]};
            assign take[n] = (rem2[n] >= (RW+1)'(den_reg[k]));
            assign diff[n] = rem2[n] - (RW+1)'(den_reg[k]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k+1] <= den_reg[k];
                tag_reg[k+1] <= tag_reg[k];
                for (int n = 0; n < L; n++)
                begin
                    rem_reg[k+1][n] <= take[n] ? diff[n][RW-1:0] : rem2[n][RW-1:0];
                    lo_reg[k+1][n]  <= lo_reg[k][n];
                    quo_reg[k+1][n] <= {quo_reg[k][n][QUO_W-2:0], take[n]};
                    ovf_reg[k+1][n] <= ovf_reg[k][n];
                end
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign out_tag   = tag_reg[QUO_W];
    for (genvar n = 0; n < L; n++)
    begin : g_out
        assign out_quo[n] = quo_reg[QUO_W][n];
        assign out_ovf[n] = ovf_reg[QUO_W][n];
    end
endmodule
`default_nettype wire
